>>> rtl/core/tga_pkg.sv
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared payload types, result kinds and header constants for the decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

  // Result kinds
  localparam logic [2:0] KIND_PIXEL    = 3'd0;
  localparam logic [2:0] KIND_HEADER   = 3'd1;
  localparam logic [2:0] KIND_NOT_TGA  = 3'd2;
  localparam logic [2:0] KIND_BAD_DEPTH = 3'd3;
  localparam logic [2:0] KIND_TOO_LARGE = 3'd4;

  // Header layout
  localparam logic [4:0] HDR_FIXED_LEN = 5'd12;
  localparam logic [4:0] HDR_TYPE_POS  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH_POS = 5'd16;
  localparam logic [4:0] HDR_DESC_POS  = 5'd17;

  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [15:0] MAX_DIM_RESET = 16'd4096;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } tga_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [31:0] first_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        is_last;
  } tga_out_t;

  // Record passed from the parser to the output stage (no pixel index yet)
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        is_last;
  } tga_rec_t;

endpackage

>>> rtl/core/tga_front.sv
// ----------------------------------------------------------------------------
// TGA decoder front end
// Parses header, packet and pixel bytes and builds one record per result.
// ----------------------------------------------------------------------------
module tga_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tga_pkg::tga_in_t item,
  input  logic [15:0]     max_dimension,
  output logic            rec_valid,
  output tga_pkg::tga_rec_t rec
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PACKET = 4'b0010,
    PH_PIXEL  = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next, eff_phase;
  logic [4:0]  hdr_count, hdr_count_next, eff_count;
  logic        run_coded, run_coded_next, eff_rle;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        four_channels, four_channels_next;
  logic [7:0]  packet_remaining, packet_remaining_next;
  logic        packet_repeats, packet_repeats_next;
  logic [1:0]  pixel_byte_count, pixel_byte_count_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [31:0] pixel_total;
  logic [7:0]  pixel_bytes [4];
  logic        pix_we;
  logic [7:0]  b;
  logic        left_small;
  logic [7:0]  len;

  assign b         = item.data_byte;
  assign eff_phase = item.start_of_file ? PH_HEADER : phase;
  assign eff_count = item.start_of_file ? 5'd0 : hdr_count;
  assign eff_rle   = item.start_of_file ? 1'b0 : run_coded;
  assign left_small = (pixels_left[31:8] == 24'd0) && (pixels_left[7:0] < packet_remaining);

  always_comb begin
    phase_next            = phase;
    hdr_count_next        = hdr_count;
    run_coded_next        = run_coded;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    four_channels_next    = four_channels;
    packet_remaining_next = packet_remaining;
    packet_repeats_next   = packet_repeats;
    pixel_byte_count_next = pixel_byte_count;
    pixels_left_next      = pixels_left;
    pix_we                = 1'b0;
    len                   = 8'd1;
    rec_valid             = 1'b0;
    rec                   = '0;
    if (accept) begin
      phase_next     = eff_phase;
      hdr_count_next = eff_count;
      run_coded_next = eff_rle;
      case (eff_phase)
        PH_HEADER: begin
          if (eff_count < tga_pkg::HDR_FIXED_LEN) begin
            if (eff_count == tga_pkg::HDR_TYPE_POS) begin
              if (b == tga_pkg::TYPE_RLE) begin
                run_coded_next = 1'b1;
              end
              if (b != tga_pkg::TYPE_RLE && b != tga_pkg::TYPE_RAW) begin
                rec_valid = 1'b1;
              end
            end else if (b != 8'd0) begin
              rec_valid = 1'b1;
            end
            if (rec_valid) begin
              rec.kind    = tga_pkg::KIND_NOT_TGA;
              rec.is_last = 1'b1;
              phase_next  = PH_IDLE;
            end else begin
              hdr_count_next = eff_count + 5'd1;
            end
          end else begin
            case (eff_count)
              tga_pkg::HDR_WIDTH_LO: begin
                width_reg_next = {8'd0, b};
                hdr_count_next = eff_count + 5'd1;
              end
              tga_pkg::HDR_WIDTH_HI: begin
                width_reg_next = {b, width_reg[7:0]};
                hdr_count_next = eff_count + 5'd1;
              end
              tga_pkg::HDR_HEIGHT_LO: begin
                height_reg_next = {8'd0, b};
                hdr_count_next  = eff_count + 5'd1;
              end
              tga_pkg::HDR_HEIGHT_HI: begin
                height_reg_next = {b, height_reg[7:0]};
                hdr_count_next  = eff_count + 5'd1;
              end
              tga_pkg::HDR_DEPTH_POS: begin
                if (b == tga_pkg::DEPTH_24 || b == tga_pkg::DEPTH_32) begin
                  four_channels_next = (b == tga_pkg::DEPTH_32);
                  hdr_count_next     = eff_count + 5'd1;
                end else begin
                  rec_valid   = 1'b1;
                  rec.kind    = tga_pkg::KIND_BAD_DEPTH;
                  rec.is_last = 1'b1;
                  phase_next  = PH_IDLE;
                end
              end
              default: begin
                // descriptor byte: size check, then start of pixel data
                rec_valid        = 1'b1;
                rec.image_width  = width_reg;
                rec.image_height = height_reg;
                if (width_reg > max_dimension || height_reg > max_dimension) begin
                  rec.kind    = tga_pkg::KIND_TOO_LARGE;
                  rec.is_last = 1'b1;
                  phase_next  = PH_IDLE;
                end else begin
                  rec.kind              = tga_pkg::KIND_HEADER;
                  rec.has_alpha         = four_channels;
                  packet_remaining_next = 8'd0;
                  packet_repeats_next   = 1'b0;
                  pixel_byte_count_next = 2'd0;
                  pixels_left_next      = pixel_total;
                  if (width_reg == 16'd0 || height_reg == 16'd0) begin
                    rec.is_last = 1'b1;
                    phase_next  = PH_IDLE;
                  end else begin
                    phase_next = eff_rle ? PH_PACKET : PH_PIXEL;
                  end
                end
              end
            endcase
          end
        end
        PH_PACKET: begin
          packet_remaining_next = {1'b0, b[6:0]} + 8'd1;
          packet_repeats_next   = b[7];
          pixel_byte_count_next = 2'd0;
          phase_next            = PH_PIXEL;
        end
        PH_PIXEL: begin
          pix_we = 1'b1;
          if (pixel_byte_count != (four_channels ? 2'd3 : 2'd2)) begin
            pixel_byte_count_next = pixel_byte_count + 2'd1;
          end else begin
            pixel_byte_count_next = 2'd0;
            if (run_coded && packet_repeats) begin
              len                   = left_small ? pixels_left[7:0] : packet_remaining;
              packet_remaining_next = 8'd0;
            end else begin
              len = 8'd1;
              if (run_coded && packet_remaining != 8'd0) begin
                packet_remaining_next = packet_remaining - 8'd1;
              end
            end
            pixels_left_next = pixels_left - {24'd0, len};
            rec_valid      = 1'b1;
            rec.kind       = tga_pkg::KIND_PIXEL;
            rec.red        = four_channels ? pixel_bytes[2] : b;
            rec.green      = pixel_bytes[1];
            rec.blue       = pixel_bytes[0];
            rec.alpha      = four_channels ? b : tga_pkg::ALPHA_OPAQUE;
            rec.run_length = len;
            rec.has_alpha  = four_channels;
            rec.is_last    = (pixels_left_next == 32'd0);
            if (rec.is_last) begin
              phase_next = PH_IDLE;
            end else if (run_coded && packet_remaining_next == 8'd0) begin
              phase_next = PH_PACKET;
            end else begin
              phase_next = PH_PIXEL;
            end
          end
        end
        default: begin
          // drop bytes until the next start of file
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      hdr_count        <= 5'd0;
      run_coded        <= 1'b0;
      width_reg        <= 16'd0;
      height_reg       <= 16'd0;
      four_channels    <= 1'b0;
      packet_remaining <= 8'd0;
      packet_repeats   <= 1'b0;
      pixel_byte_count <= 2'd0;
      pixels_left      <= 32'd0;
    end else begin
      phase            <= phase_next;
      hdr_count        <= hdr_count_next;
      run_coded        <= run_coded_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
      four_channels    <= four_channels_next;
      packet_remaining <= packet_remaining_next;
      packet_repeats   <= packet_repeats_next;
      pixel_byte_count <= pixel_byte_count_next;
      pixels_left      <= pixels_left_next;
    end
  end

  // Image size product, settled well before the descriptor byte arrives
  always_ff @(posedge clk) begin
    pixel_total <= {16'd0, width_reg} * {16'd0, height_reg};
    if (pix_we) begin
      pixel_bytes[pixel_byte_count] <= b;
    end
  end

endmodule

>>> rtl/core/tga_queue.sv
// ----------------------------------------------------------------------------
// TGA decoder record queue
// Four-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module tga_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  tga_pkg::tga_rec_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output tga_pkg::tga_rec_t rd_data,
  output logic              empty
);

  tga_pkg::tga_rec_t entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       do_wr, do_rd;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 3'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/tga_back.sv
// ----------------------------------------------------------------------------
// TGA decoder output stage
// Numbers pixel runs and holds the result register for the receiver.
// ----------------------------------------------------------------------------
module tga_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  tga_pkg::tga_rec_t  rec,
  output logic               rec_take,
  output tga_pkg::tga_out_t  result,
  output logic               empty,
  input  logic               pop
);

  logic        out_valid;
  logic [31:0] pixels_done;

  assign empty    = !out_valid;
  assign rec_take = rec_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      pixels_done <= 32'd0;
    end else begin
      if (rec_take) begin
        out_valid <= 1'b1;
        if (rec.kind == tga_pkg::KIND_PIXEL) begin
          pixels_done <= pixels_done + {24'd0, rec.run_length};
        end else if (rec.kind == tga_pkg::KIND_HEADER) begin
          pixels_done <= 32'd0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      result.kind         <= rec.kind;
      result.red          <= rec.red;
      result.green        <= rec.green;
      result.blue         <= rec.blue;
      result.alpha        <= rec.alpha;
      result.run_length   <= rec.run_length;
      result.first_index  <= (rec.kind == tga_pkg::KIND_PIXEL) ? pixels_done : 32'd0;
      result.image_width  <= rec.image_width;
      result.image_height <= rec.image_height;
      result.has_alpha    <= rec.has_alpha;
      result.is_last      <= rec.is_last;
    end
  end

endmodule

>>> rtl/core/tga_rle_image_decoder.sv
// ----------------------------------------------------------------------------
// TGA true-color image decoder
// Byte-stream TGA parser producing header status and RGBA pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive byte_item and raise push; a transaction happens at a
//   clock edge with push high and full low. Set start_of_file on the first
//   byte of each file to restart parsing.
//   Result channel: while empty is low, result holds the oldest result; raise
//   pop to take it. Each result is a header status, an error, or a pixel run.
//   Configuration: cfg_write with cfg_data sets max_dimension (reset 4096);
//   write it only while no file is in flight.
// Throughput: one byte per cycle, sustained, as long as the receiver pops at
//   least one result per cycle. The parser sets this rate.
// Result path: the edge that accepts the byte completing a result writes its
//   record into the queue; the output register takes it from the queue when
//   it is empty or being popped, and drives the result ports.
// Stalls: a four-entry queue sits between parser and output register; when
//   the receiver holds off, the queue fills and full rises, holding the input.
// Reset: synchronous rst empties the queue and the output register, returns
//   the parser to header byte 0 and restores max_dimension to 4096.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tga_pkg::tga_in_t   byte_item,
  output logic               empty,
  input  logic               pop,
  output tga_pkg::tga_out_t  result,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  logic [15:0]       max_dimension;
  logic              accept;
  logic              rec_valid;
  tga_pkg::tga_rec_t rec;
  tga_pkg::tga_rec_t q_data;
  logic              q_empty;
  logic              q_take;

  // Size limit, unchecked: written by the user only while the decoder is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dimension <= tga_pkg::MAX_DIM_RESET;
    end else if (cfg_write) begin
      max_dimension <= cfg_data;
    end
  end

  // Accept a byte whenever the queue has room for the record it may make
  assign accept = push && !full;

  tga_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (byte_item),
    .max_dimension (max_dimension),
    .rec_valid     (rec_valid),
    .rec           (rec)
  );

  tga_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  tga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!q_empty),
    .rec       (q_data),
    .rec_take  (q_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

>>> test/tga_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder result checker
// Watches the byte, result and configuration channels of the decoder, keeps
// its own copy of the parser state, predicts every result and compares each
// popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tga_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  tga_pkg::tga_in_t   byte_item,
  input  logic               empty,
  input  logic               pop,
  input  tga_pkg::tga_out_t  result,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  import tga_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PACKET,
    PH_PIXEL,
    PH_DONE
  } parse_phase_t;

  // Shadow copy of the decoder state
  logic [15:0]  max_dim;
  parse_phase_t phase;
  logic [4:0]   hdr_pos;
  logic         rle_mode;
  logic         alpha_mode;
  logic [15:0]  img_w;
  logic [15:0]  img_h;
  logic [7:0]   packet_left;
  logic         repeat_packet;
  logic [7:0]   pix [4];
  logic [1:0]   pix_pos;
  logic [31:0]  pix_done;

  tga_out_t pending_results[$];
  int       errors = 0;

  function automatic void restart_file();
    phase         = PH_HEADER;
    hdr_pos       = '0;
    rle_mode      = 1'b0;
    alpha_mode    = 1'b0;
    img_w         = '0;
    img_h         = '0;
    packet_left   = '0;
    repeat_packet = 1'b0;
    pix[0]        = '0;
    pix[1]        = '0;
    pix[2]        = '0;
    pix[3]        = ALPHA_OPAQUE;
    pix_pos       = '0;
    pix_done      = '0;
  endfunction

  // Header status or error result; park the parser unless pixels follow
  function automatic tga_out_t status_of(input logic [2:0] kind, input logic last);
    tga_out_t r;
    r = '0;
    r.kind = kind;
    if (kind == KIND_HEADER || kind == KIND_TOO_LARGE) begin
      r.image_width  = img_w;
      r.image_height = img_h;
    end
    if (kind == KIND_HEADER) r.has_alpha = alpha_mode;
    r.is_last = last;
    if (kind != KIND_HEADER || last) phase = PH_DONE;
    return r;
  endfunction

  // Advance the shadow parser by one byte; return 1 when a result is due
  function automatic bit decode_byte(input tga_in_t it, output tga_out_t r);
    logic [7:0]  b;
    logic [31:0] total;
    logic [31:0] left;
    logic [31:0] len;
    logic [2:0]  chans;
    b = it.data_byte;
    r = '0;
    if (it.start_of_file) restart_file();
    total = 32'(img_w) * 32'(img_h);
    case (phase)
      PH_HEADER: begin
        if (hdr_pos < HDR_FIXED_LEN) begin
          if (hdr_pos == HDR_TYPE_POS) begin
            if (b == TYPE_RLE) rle_mode = 1'b1;
            else if (b != TYPE_RAW) begin
              r = status_of(KIND_NOT_TGA, 1'b1);
              return 1'b1;
            end
          end else if (b != 8'd0) begin
            r = status_of(KIND_NOT_TGA, 1'b1);
            return 1'b1;
          end
        end else if (hdr_pos == HDR_WIDTH_LO) begin
          img_w = {8'd0, b};
        end else if (hdr_pos == HDR_WIDTH_HI) begin
          img_w[15:8] = b;
        end else if (hdr_pos == HDR_HEIGHT_LO) begin
          img_h = {8'd0, b};
        end else if (hdr_pos == HDR_HEIGHT_HI) begin
          img_h[15:8] = b;
        end else if (hdr_pos == HDR_DEPTH_POS) begin
          if (b == DEPTH_24) alpha_mode = 1'b0;
          else if (b == DEPTH_32) alpha_mode = 1'b1;
          else begin
            r = status_of(KIND_BAD_DEPTH, 1'b1);
            return 1'b1;
          end
        end else begin
          // Descriptor byte: size check, then start on pixels
          if (img_w > max_dim || img_h > max_dim) begin
            r = status_of(KIND_TOO_LARGE, 1'b1);
            return 1'b1;
          end
          pix_done      = '0;
          packet_left   = '0;
          repeat_packet = 1'b0;
          pix_pos       = '0;
          if (total == 0) begin
            r = status_of(KIND_HEADER, 1'b1);
            return 1'b1;
          end
          phase = rle_mode ? PH_PACKET : PH_PIXEL;
          r = status_of(KIND_HEADER, 1'b0);
          return 1'b1;
        end
        hdr_pos = hdr_pos + 5'd1;
        return 1'b0;
      end
      PH_PACKET: begin
        packet_left   = {1'b0, b[6:0]} + 8'd1;
        repeat_packet = b[7];
        pix_pos       = '0;
        phase         = PH_PIXEL;
        return 1'b0;
      end
      PH_PIXEL: begin
        pix[pix_pos] = b;
        chans = alpha_mode ? 3'd4 : 3'd3;
        if ({1'b0, pix_pos} + 3'd1 < chans) begin
          pix_pos = pix_pos + 2'd1;
          return 1'b0;
        end
        pix_pos = '0;
        left = total - pix_done;
        if (rle_mode && repeat_packet) begin
          // Clip a repeat run at the end of the image
          len = (32'(packet_left) < left) ? 32'(packet_left) : left;
          packet_left = '0;
        end else begin
          len = 32'd1;
          if (rle_mode && packet_left != 0) packet_left = packet_left - 8'd1;
        end
        r.kind        = KIND_PIXEL;
        r.red         = pix[2];
        r.green       = pix[1];
        r.blue        = pix[0];
        r.alpha       = alpha_mode ? pix[3] : ALPHA_OPAQUE;
        r.run_length  = len[7:0];
        r.first_index = pix_done;
        r.has_alpha   = alpha_mode;
        pix_done      = pix_done + len;
        r.is_last     = (pix_done >= total);
        if (r.is_last) phase = PH_DONE;
        else if (rle_mode && packet_left == 0) phase = PH_PACKET;
        else phase = PH_PIXEL;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    tga_out_t want;
    tga_out_t predicted;
    if (rst) begin
      max_dim = MAX_DIM_RESET;
      restart_file();
      pending_results.delete();
    end else begin
      // Results already in flight come from earlier bytes: check first
      if (!empty && pop) begin
        if (pending_results.size() == 0) begin
          $error("result with no prediction waiting: kind 0x%0h", result.kind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind",         32'(want.kind),         32'(result.kind));
          compare_field("red",          32'(want.red),          32'(result.red));
          compare_field("green",        32'(want.green),        32'(result.green));
          compare_field("blue",         32'(want.blue),         32'(result.blue));
          compare_field("alpha",        32'(want.alpha),        32'(result.alpha));
          compare_field("run_length",   32'(want.run_length),   32'(result.run_length));
          compare_field("first_index",  want.first_index,       result.first_index);
          compare_field("image_width",  32'(want.image_width),  32'(result.image_width));
          compare_field("image_height", 32'(want.image_height), 32'(result.image_height));
          compare_field("has_alpha",    32'(want.has_alpha),    32'(result.has_alpha));
          compare_field("is_last",      32'(want.is_last),      32'(result.is_last));
        end
      end
      if (push && !full) begin
        if (decode_byte(byte_item, predicted)) pending_results.push_back(predicted);
      end
      if (cfg_write) max_dim = cfg_data;
    end
    mismatches  <= errors;
    outstanding <= pending_results.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder testbench
// Feeds TGA byte streams into the decoder: a directed set of headers, errors
// and RLE corner cases, then random files under several size limits, with
// random idle bursts on both channels. A checker beside the block predicts
// and compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tga_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  tga_in_t     byte_item;
  logic        empty;
  logic        pop;
  tga_out_t    result;
  logic        cfg_write;
  logic [15:0] cfg_data;

  int mismatches;
  int outstanding;

  // Idle enables for the byte side and the result side
  bit          send_idle;
  bit          take_idle;
  // Size limit currently programmed, used to skip pixels of rejected images
  logic [15:0] cur_max;
  // Bytes of the file under construction
  tga_in_t     file_q[$];

  tga_rle_image_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  tga_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .byte_item   (byte_item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Result side: pop most cycles, stall in random bursts
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (take_idle && $urandom_range(0, 5) == 0) begin
        hold_cycles = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void add_byte(input logic [7:0] b, input logic sof);
    tga_in_t it;
    it.data_byte     = b;
    it.start_of_file = sof;
    file_q.push_back(it);
  endfunction

  function automatic void add_header(input logic [7:0] img_type, input logic [15:0] w,
                                     input logic [15:0] h, input logic [7:0] depth,
                                     input logic sof);
    for (int i = 0; i < HDR_FIXED_LEN; i++)
      add_byte((i == HDR_TYPE_POS) ? img_type : 8'd0, sof && i == 0);
    add_byte(w[7:0], 1'b0);
    add_byte(w[15:8], 1'b0);
    add_byte(h[7:0], 1'b0);
    add_byte(h[15:8], 1'b0);
    add_byte(depth, 1'b0);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void add_pixel(input logic alpha);
    repeat (alpha ? 4 : 3) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // Packets with random counts; repeat runs may overshoot the end (clipped),
  // raw packets overshoot by at most one ignored pixel
  function automatic void add_rle_pixels(input logic alpha, input int total);
    int   left;
    int   cnt;
    int   n;
    logic rep;
    left = total;
    while (left > 0) begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
      rep = 1'($urandom_range(0, 1));
      add_byte({rep, 7'(cnt - 1)}, 1'b0);
      if (rep) begin
        add_pixel(alpha);
        left -= cnt;
      end else begin
        n = (cnt > left) ? left + int'($urandom_range(0, 7) == 0) : cnt;
        repeat (n) add_pixel(alpha);
        left -= n;
      end
    end
  endfunction

  // Well-formed file with random type, depth, size and pixel content
  function automatic void add_good_file();
    logic        rle;
    logic        alpha;
    logic [15:0] w;
    logic [15:0] h;
    int          sel;
    int          total;
    rle   = 1'($urandom_range(0, 1));
    alpha = 1'($urandom_range(0, 1));
    sel   = $urandom_range(0, 11);
    w     = 16'($urandom_range(1, 6));
    h     = 16'($urandom_range(1, 4));
    if (sel == 0) begin
      w = 16'($urandom_range(0, 65535));
      h = '0;
    end else if (sel == 1) begin
      h = 16'($urandom_range(0, 65535));
      w = '0;
    end else if (sel == 2) begin
      w = 16'($urandom_range(0, 6));
      h = 16'($urandom_range(0, 8));
    end
    add_header(rle ? TYPE_RLE : TYPE_RAW, w, h, alpha ? DEPTH_32 : DEPTH_24, 1'b1);
    total = int'(w) * int'(h);
    if (w <= cur_max && h <= cur_max && total > 0) begin
      if (rle) add_rle_pixels(alpha, total);
      else repeat (total) add_pixel(alpha);
    end
  endfunction

  // Build one random file into file_q; return how many bytes to count
  function automatic int random_file();
    int          sel;
    int          pos;
    int          keep;
    logic [7:0]  b;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      add_good_file();
    end else if (sel < 78) begin
      // Header mismatch at a random fixed position, then junk
      pos = $urandom_range(0, 11);
      for (int i = 0; i < pos; i++)
        add_byte((i == HDR_TYPE_POS) ? ($urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW) : 8'd0,
                 i == 0);
      if (pos == HDR_TYPE_POS) begin
        do b = 8'($urandom_range(0, 255)); while (b == TYPE_RAW || b == TYPE_RLE);
      end else begin
        b = 8'($urandom_range(1, 255));
      end
      add_byte(b, pos == 0);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (sel < 85) begin
      do b = 8'($urandom_range(0, 255)); while (b == DEPTH_24 || b == DEPTH_32);
      add_header($urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW, 16'($urandom_range(0, 8)),
                 16'($urandom_range(0, 8)), b, 1'b1);
    end else if (sel < 93) begin
      // Cut a good file short; the next start of file restarts parsing
      add_good_file();
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end else begin
      // Noise: ignored after an end, or taken as header bytes mid-file
      add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      return 0;
    end
    return file_q.size();
  endfunction

  // Offer one byte and hold it until a transaction happens
  task automatic send_item(input tga_in_t it);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_item <= it;
    push      <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i]);
    file_q.delete();
  endtask

  // Drain, let the parser settle, then program the size limit
  task automatic set_max(input logic [15:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_max = v;
  endtask

  initial begin
    int phase_bytes;
    rst       <= 1'b1;
    push      <= 1'b0;
    byte_item <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    cur_max   = MAX_DIM_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Raw 24-bit 2x1 with no start of file after reset, extreme pixel bytes
    add_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_24, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'hff, 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hff, 1'b0);
    // Wrong first byte, then a byte that must be ignored
    add_byte(8'h01, 1'b1);
    add_byte(8'h00, 1'b0);
    // Wrong image type
    add_byte(8'h00, 1'b1); add_byte(8'h00, 1'b0); add_byte(8'h03, 1'b0);
    // Wrong last fixed byte
    for (int i = 0; i < HDR_FIXED_LEN - 1; i++)
      add_byte((i == HDR_TYPE_POS) ? TYPE_RAW : 8'd0, i == 0);
    add_byte(8'h80, 1'b0);
    // Bad depth, checked before an oversize width
    add_header(TYPE_RAW, 16'd5000, 16'd1, 8'd16, 1'b1);
    // Too large on width, then on height
    add_header(TYPE_RLE, 16'd4097, 16'd1, DEPTH_24, 1'b1);
    add_header(TYPE_RAW, 16'd1, 16'hffff, DEPTH_32, 1'b1);
    // Empty image: header result is the last
    add_header(TYPE_RLE, 16'd0, 16'd5, DEPTH_32, 1'b1);
    // Repeat run of 5 clipped to a 3-pixel image
    add_header(TYPE_RLE, 16'd3, 16'd1, DEPTH_32, 1'b1);
    add_byte(8'h84, 1'b0);
    add_byte(8'hff, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hff, 1'b0); add_byte(8'h00, 1'b0);
    // Full 128-pixel repeat run
    add_header(TYPE_RLE, 16'd128, 16'd1, DEPTH_24, 1'b1);
    add_byte(8'hff, 1'b0);
    add_pixel(1'b0);
    // Raw packet of two, then a repeat and a raw packet
    add_header(TYPE_RLE, 16'd2, 16'd1, DEPTH_32, 1'b1);
    add_byte(8'h01, 1'b0);
    add_pixel(1'b1); add_pixel(1'b1);
    add_header(TYPE_RLE, 16'd4, 16'd1, DEPTH_24, 1'b1);
    add_byte(8'h81, 1'b0); add_pixel(1'b0);
    add_byte(8'h01, 1'b0); add_pixel(1'b0); add_pixel(1'b0);
    // Restart in the middle of the pixel data
    add_header(TYPE_RAW, 16'd2, 16'd2, DEPTH_24, 1'b1);
    add_pixel(1'b0); add_byte(8'h55, 1'b0);
    add_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_32, 1'b1);
    add_pixel(1'b1);
    send_file();

    // Largest limit: full 16-bit sizes pass
    set_max(16'hffff);
    add_header(TYPE_RAW, 16'hffff, 16'd0, DEPTH_32, 1'b1);
    add_header(TYPE_RLE, 16'd0, 16'hffff, DEPTH_24, 1'b1);
    send_file();
    // Smallest useful limit
    set_max(16'd1);
    add_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_24, 1'b1);
    add_byte(8'h80, 1'b0); add_pixel(1'b0);
    add_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_24, 1'b1);
    add_header(TYPE_RAW, 16'd1, 16'd2, DEPTH_24, 1'b1);
    send_file();
    // Zero limit rejects any nonzero width or height
    set_max(16'd0);
    add_header(TYPE_RAW, 16'd0, 16'd0, DEPTH_24, 1'b1);
    add_header(TYPE_RAW, 16'd1, 16'd0, DEPTH_32, 1'b1);
    send_file();

    // Random files under a run of limits; the last phase has no idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_max(MAX_DIM_RESET);
        1: set_max(16'($urandom_range(1, 8)));
        2: set_max(16'hffff);
        3: set_max(16'($urandom_range(1, 65535)));
        4: set_max(16'd1);
        default: set_max(16'($urandom_range(2, 6)));
      endcase
      send_idle = (ph != 2) && (ph != 5);
      take_idle = (ph != 1) && (ph != 5);
      phase_bytes = 0;
      while (phase_bytes < 90) begin
        phase_bytes += random_file();
        send_file();
      end
    end

    // Wait for every predicted result, then watch for strays
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
